@@ hdl/rgpc_pkg.sv @@
// rgpc_pkg: widths, register indexes and reset values of the ray ground point classifier
package rgpc_pkg;

    // field widths
    localparam int RadiusW = 18;
    localparam int HeightW = 16;
    localparam int IndexW  = 20;
    localparam int TanW    = 18;
    localparam int MinHW   = 15;
    localparam int GapW    = 18;
    localparam int FracW   = 16;

    // configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 18;

    // derived widths
    localparam int StepW  = RadiusW + 1;               // signed radial step
    localparam int ProdW  = TanW + RadiusW;            // tangent times length
    localparam int ThrW   = ProdW - FracW;             // product after the Q16 shift
    localparam int DiffW  = HeightW + 1;               // height difference
    localparam int CmpW   = ThrW + 2;                  // signed compare width

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx RegLocalSlopeTan   = 3'd0;
    localparam t_cfg_idx RegInitialSlopeTan = 3'd1;
    localparam t_cfg_idx RegGeneralSlopeTan = 3'd2;
    localparam t_cfg_idx RegMinHeightMm     = 3'd3;
    localparam t_cfg_idx RegConcentricGapMm = 3'd4;
    localparam t_cfg_idx RegReclassGapMm    = 3'd5;

    // register reset values
    localparam logic [TanW-1:0]  RstLocalSlopeTan   = 18'd5734;
    localparam logic [TanW-1:0]  RstInitialSlopeTan = 18'd3435;
    localparam logic [TanW-1:0]  RstGeneralSlopeTan = 18'd3435;
    localparam logic [MinHW-1:0] RstMinHeightMm     = 15'd50;
    localparam logic [GapW-1:0]  RstConcentricGapMm = 18'd0;
    localparam logic [GapW-1:0]  RstReclassGapMm    = 18'd100;

endpackage

@@ hdl/ray_ground_point_classifier.sv @@
// ray_ground_point_classifier: single-pass ground / non-ground classifier for sorted lidar rays
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------------------
//   point in | input     | i_valid / o_stall   | i_radius_mm, i_height_mm, i_first_of_ray,
//            |           |                     | i_point_index
//   class out| output    | o_valid / i_stall   | o_result_index, o_is_ground
//   config   | input     | i_cfg_wr_en         | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while i_stall is low; an accepted item moves from the input
// register to the result register, where its result is offered; the input register holds the
// radial step, height difference and selected slope; the two 18x18 products, the band tests
// and the one-bit previous-class loop sit between it and the result register
// i_rst_n is synchronous; it empties both registers, clears the ray history and reloads the
// configuration registers with their defaults
// a stall on the output only holds registers that are full; an empty input register still fills
module ray_ground_point_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // point in
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [rgpc_pkg::RadiusW-1:0]         i_radius_mm,
    input  logic signed [rgpc_pkg::HeightW-1:0]  i_height_mm,
    input  logic                                 i_first_of_ray,
    input  logic [rgpc_pkg::IndexW-1:0]          i_point_index,
    // class out
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [rgpc_pkg::IndexW-1:0]          o_result_index,
    output logic                                 o_is_ground,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [rgpc_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [rgpc_pkg::CfgDataW-1:0]        i_cfg_data
);

    // configuration registers
    logic [rgpc_pkg::TanW-1:0]  r_local_tan;
    logic [rgpc_pkg::TanW-1:0]  r_initial_tan;
    logic [rgpc_pkg::TanW-1:0]  r_general_tan;
    logic [rgpc_pkg::MinHW-1:0] r_min_height;
    logic [rgpc_pkg::GapW-1:0]  r_conc_gap;
    logic [rgpc_pkg::GapW-1:0]  r_reclass_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_tan   <= rgpc_pkg::RstLocalSlopeTan;
            r_initial_tan <= rgpc_pkg::RstInitialSlopeTan;
            r_general_tan <= rgpc_pkg::RstGeneralSlopeTan;
            r_min_height  <= rgpc_pkg::RstMinHeightMm;
            r_conc_gap    <= rgpc_pkg::RstConcentricGapMm;
            r_reclass_gap <= rgpc_pkg::RstReclassGapMm;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rgpc_pkg::RegLocalSlopeTan:   r_local_tan   <= i_cfg_data[rgpc_pkg::TanW-1:0];
                rgpc_pkg::RegInitialSlopeTan: r_initial_tan <= i_cfg_data[rgpc_pkg::TanW-1:0];
                rgpc_pkg::RegGeneralSlopeTan: r_general_tan <= i_cfg_data[rgpc_pkg::TanW-1:0];
                rgpc_pkg::RegMinHeightMm:     r_min_height  <= i_cfg_data[rgpc_pkg::MinHW-1:0];
                rgpc_pkg::RegConcentricGapMm: r_conc_gap    <= i_cfg_data[rgpc_pkg::GapW-1:0];
                rgpc_pkg::RegReclassGapMm:    r_reclass_gap <= i_cfg_data[rgpc_pkg::GapW-1:0];
                default: ;
            endcase
        end
    end

    // register valids and advance enables
    logic r_v1, r_v2;
    logic en1, en2;

    assign en2 = !r_v2 || !i_stall;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    logic in_acc;
    assign in_acc = i_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    // ray history seen on the input side (radius and height only)
    logic [rgpc_pkg::RadiusW-1:0]        r_last_radius;
    logic signed [rgpc_pkg::HeightW-1:0] r_last_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_radius <= '0;
            r_last_height <= '0;
        end else if (in_acc) begin
            r_last_radius <= i_radius_mm;
            r_last_height <= i_height_mm;
        end
    end

    // input register: radial step, height difference, slope select
    logic [rgpc_pkg::RadiusW-1:0]        prev_r;
    logic signed [rgpc_pkg::HeightW-1:0] prev_h;
    logic signed [rgpc_pkg::StepW-1:0]   n_step;
    logic signed [rgpc_pkg::DiffW-1:0]   hdiff;
    logic [rgpc_pkg::DiffW-1:0]          n_abs_diff;

    always_comb begin
        prev_r = i_first_of_ray ? '0 : r_last_radius;
        prev_h = i_first_of_ray ? '0 : r_last_height;
        n_step = $signed({1'b0, i_radius_mm}) - $signed({1'b0, prev_r});
        hdiff  = $signed({i_height_mm[rgpc_pkg::HeightW-1], i_height_mm})
               - $signed({prev_h[rgpc_pkg::HeightW-1], prev_h});
        n_abs_diff = hdiff[rgpc_pkg::DiffW-1] ? rgpc_pkg::DiffW'(-hdiff)
                                              : rgpc_pkg::DiffW'(hdiff);
    end

    logic signed [rgpc_pkg::StepW-1:0]   r_in_step;
    logic [rgpc_pkg::DiffW-1:0]          r_in_abs_diff;
    logic [rgpc_pkg::TanW-1:0]           r_in_tan;
    logic [rgpc_pkg::RadiusW-1:0]        r_in_radius;
    logic signed [rgpc_pkg::HeightW-1:0] r_in_height;
    logic                                r_in_first;
    logic [rgpc_pkg::IndexW-1:0]         r_in_index;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_in_step     <= n_step;
            r_in_abs_diff <= n_abs_diff;
            r_in_tan      <= i_first_of_ray ? r_initial_tan : r_local_tan;
            r_in_radius   <= i_radius_mm;
            r_in_height   <= i_height_mm;
            r_in_first    <= i_first_of_ray;
            r_in_index    <= i_point_index;
        end
    end

    // local and general slope products
    logic [rgpc_pkg::RadiusW-1:0] step_pos;
    logic [rgpc_pkg::ProdW-1:0]   prod_local;
    logic [rgpc_pkg::ProdW-1:0]   prod_general;
    logic [rgpc_pkg::ThrW-1:0]    local_t;
    logic [rgpc_pkg::ThrW-1:0]    general_g;

    always_comb begin
        step_pos = (r_in_step > 0) ? r_in_step[rgpc_pkg::RadiusW-1:0] : '0;
        prod_local   = rgpc_pkg::ProdW'(r_in_tan) * rgpc_pkg::ProdW'(step_pos);
        prod_general = rgpc_pkg::ProdW'(r_general_tan) * rgpc_pkg::ProdW'(r_in_radius);
        local_t      = prod_local[rgpc_pkg::ProdW-1:rgpc_pkg::FracW];
        general_g    = prod_general[rgpc_pkg::ProdW-1:rgpc_pkg::FracW];
    end

    // threshold, band tests and the previous-class loop
    logic                              r_last_ground;
    logic [rgpc_pkg::ThrW-1:0]         thr;
    logic signed [rgpc_pkg::CmpW-1:0]  step_x;
    logic signed [rgpc_pkg::CmpW-1:0]  conc_x;
    logic signed [rgpc_pkg::CmpW-1:0]  recl_x;
    logic signed [rgpc_pkg::CmpW-1:0]  h_x;
    logic signed [rgpc_pkg::CmpW-1:0]  g_x;
    logic                              prev_g;
    logic                              in_local;
    logic                              in_general;
    logic                              n_ground;

    always_comb begin
        thr = (local_t > rgpc_pkg::ThrW'(r_min_height)) ? local_t
                                                        : rgpc_pkg::ThrW'(r_min_height);
        step_x = rgpc_pkg::CmpW'(r_in_step);
        conc_x = $signed({{(rgpc_pkg::CmpW-rgpc_pkg::GapW){1'b0}}, r_conc_gap});
        recl_x = $signed({{(rgpc_pkg::CmpW-rgpc_pkg::GapW){1'b0}}, r_reclass_gap});
        h_x    = rgpc_pkg::CmpW'(r_in_height);
        g_x    = $signed({2'b00, general_g});
        prev_g     = r_in_first ? 1'b0 : r_last_ground;
        in_local   = rgpc_pkg::ThrW'(r_in_abs_diff) <= thr;
        in_general = (h_x <= g_x) && (h_x >= -g_x);
        if (step_x < conc_x) begin
            n_ground = prev_g;
        end else if (in_local) begin
            n_ground = prev_g || in_general;
        end else begin
            n_ground = (step_x > recl_x) && in_general;
        end
    end

    logic res_load;
    assign res_load = en2 && r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ground <= 1'b0;
        end else if (res_load) begin
            r_last_ground <= n_ground;
        end
    end

    // result register
    logic [rgpc_pkg::IndexW-1:0] r_res_index;
    logic                        r_res_ground;

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_index  <= r_in_index;
            r_res_ground <= n_ground;
        end
    end

    assign o_valid        = r_v2;
    assign o_result_index = r_res_index;
    assign o_is_ground    = r_res_ground;

    // checks
    a_full_pipe_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && i_stall) |-> o_stall)
        else $error("full pipeline under output stall still takes items");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted item did not enter the input register");

    a_class_follows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(res_load) |-> (r_last_ground == o_is_ground))
        else $error("class history differs from last delivered class");

    a_result_only_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> !$past(i_stall))
        else $error("result dropped while output stalled");

endmodule

@@ tb/ray_ground_point_classifier_test.sv @@
// ray_ground_point_classifier_test: self-checking testbench of the ray ground point classifier
`timescale 1ns / 1ps

module ray_ground_point_classifier_test;

    localparam int ClkHalf        = 6;
    localparam int ResetCycles    = 8;
    localparam int NumPhases      = 8;
    localparam int ItemsPerPhase  = 125;
    localparam int LongHold       = 200;
    localparam int IdleLimit      = 3000;
    localparam int DrainCycles    = 4;
    localparam int TailCycles     = 10;
    localparam int MaxReports     = 10;
    localparam logic [rgpc_pkg::RadiusW-1:0] RadiusMax = '1;

    // indexes past the end of the register list
    localparam rgpc_pkg::t_cfg_idx RegSpareLo = 3'd6;
    localparam rgpc_pkg::t_cfg_idx RegSpareHi = 3'd7;

    typedef enum logic [1:0] {
        StallNone,
        StallLight,
        StallHeavy,
        StallToggle
    } t_stall_mode;

    typedef struct packed {
        logic [rgpc_pkg::IndexW-1:0] index;
        logic                        ground;
    } t_point_class;

    // predicted classification of accepted points, oldest first
    class t_ground_scoreboard;
        t_point_class                        class_q[$];
        logic [rgpc_pkg::TanW-1:0]           local_tan;
        logic [rgpc_pkg::TanW-1:0]           initial_tan;
        logic [rgpc_pkg::TanW-1:0]           general_tan;
        logic [rgpc_pkg::MinHW-1:0]          min_height;
        logic [rgpc_pkg::GapW-1:0]           concentric_gap;
        logic [rgpc_pkg::GapW-1:0]           reclass_gap;
        logic [rgpc_pkg::RadiusW-1:0]        ray_radius;
        logic signed [rgpc_pkg::HeightW-1:0] ray_height;
        logic                                ray_ground;
        int                                  mismatches;

        function new();
            local_tan      = rgpc_pkg::RstLocalSlopeTan;
            initial_tan    = rgpc_pkg::RstInitialSlopeTan;
            general_tan    = rgpc_pkg::RstGeneralSlopeTan;
            min_height     = rgpc_pkg::RstMinHeightMm;
            concentric_gap = rgpc_pkg::RstConcentricGapMm;
            reclass_gap    = rgpc_pkg::RstReclassGapMm;
            ray_radius     = '0;
            ray_height     = '0;
            ray_ground     = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_config(rgpc_pkg::t_cfg_idx idx,
                                   logic [rgpc_pkg::CfgDataW-1:0] data);
            case (idx)
                rgpc_pkg::RegLocalSlopeTan:   local_tan      = data[rgpc_pkg::TanW-1:0];
                rgpc_pkg::RegInitialSlopeTan: initial_tan    = data[rgpc_pkg::TanW-1:0];
                rgpc_pkg::RegGeneralSlopeTan: general_tan    = data[rgpc_pkg::TanW-1:0];
                rgpc_pkg::RegMinHeightMm:     min_height     = data[rgpc_pkg::MinHW-1:0];
                rgpc_pkg::RegConcentricGapMm: concentric_gap = data[rgpc_pkg::GapW-1:0];
                rgpc_pkg::RegReclassGapMm:    reclass_gap    = data[rgpc_pkg::GapW-1:0];
                default: ;
            endcase
        endfunction

        // classify one accepted point and advance the ray history
        function void note_point(logic [rgpc_pkg::RadiusW-1:0] radius,
                                 logic signed [rgpc_pkg::HeightW-1:0] height,
                                 logic first, logic [rgpc_pkg::IndexW-1:0] index);
            longint                    base_r;
            longint                    base_h;
            longint                    h;
            longint                    step;
            longint                    thr;
            longint                    prod;
            longint                    gen_thr;
            logic                      base_g;
            logic                      in_band;
            logic                      ground;
            logic [rgpc_pkg::TanW-1:0] tan_sel;
            t_point_class              item;

            base_r  = first ? 0 : longint'(ray_radius);
            base_h  = first ? 0 : longint'(ray_height);
            base_g  = first ? 1'b0 : ray_ground;
            tan_sel = first ? initial_tan : local_tan;
            h       = longint'(height);
            step    = longint'(radius) - base_r;

            // local threshold, floored at the minimum height
            thr = longint'(min_height);
            if (step > 0) begin
                prod = (longint'(tan_sel) * step) >>> rgpc_pkg::FracW;
                if (prod > thr)
                    thr = prod;
            end

            // general band from the origin
            gen_thr = (longint'(general_tan) * longint'(radius)) >>> rgpc_pkg::FracW;
            in_band = (h <= gen_thr) && (h >= -gen_thr);

            if (step < longint'(concentric_gap))
                ground = base_g;
            else if (h <= base_h + thr && h >= base_h - thr)
                ground = base_g ? 1'b1 : in_band;
            else
                ground = (step > longint'(reclass_gap)) && in_band;

            ray_radius = radius;
            ray_height = height;
            ray_ground = ground;

            item.index  = index;
            item.ground = ground;
            class_q.insert(class_q.size(), item);
        endfunction

        function void check_result(logic [rgpc_pkg::IndexW-1:0] index, logic ground);
            t_point_class want;

            if (class_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("unexpected result: index %0d ground %0b", index, ground);
            end else begin
                want = class_q.pop_front();
                if (index !== want.index || ground !== want.ground) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("mismatch: index exp %0d got %0d, ground exp %0b got %0b",
                                 want.index, index, want.ground, ground);
                end
            end
        endfunction

        function int pending();
            return class_q.size();
        endfunction
    endclass

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_valid        = 1'b0;
    logic                                o_stall;
    logic [rgpc_pkg::RadiusW-1:0]        i_radius_mm    = '0;
    logic signed [rgpc_pkg::HeightW-1:0] i_height_mm    = '0;
    logic                                i_first_of_ray = 1'b0;
    logic [rgpc_pkg::IndexW-1:0]         i_point_index  = '0;
    logic                                o_valid;
    logic                                i_stall        = 1'b0;
    logic [rgpc_pkg::IndexW-1:0]         o_result_index;
    logic                                o_is_ground;
    logic                                i_cfg_wr_en    = 1'b0;
    rgpc_pkg::t_cfg_idx                  i_cfg_index    = '0;
    logic [rgpc_pkg::CfgDataW-1:0]       i_cfg_data     = '0;

    t_ground_scoreboard sb;
    int          burst_left   = 0;
    int          hold_left    = 0;
    int          mode_left    = 0;
    int          idle_cycles  = 0;
    logic        hold_request = 1'b0;
    t_stall_mode stall_mode   = StallNone;

    ray_ground_point_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_radius_mm    (i_radius_mm),
        .i_height_mm    (i_height_mm),
        .i_first_of_ray (i_first_of_ray),
        .i_point_index  (i_point_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_index (o_result_index),
        .o_is_ground    (o_is_ground),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always #ClkHalf i_clk = ~i_clk;

    // result side: check accepted results, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_result_index, o_is_ground);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LongHold;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                StallNone:  i_stall <= 1'b0;
                StallLight: i_stall <= ($urandom_range(0, 3) == 0);
                StallHeavy: i_stall <= ($urandom_range(0, 3) != 0);
                default:    i_stall <= ~i_stall;
            endcase
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // random register value up to a bound
    function automatic logic [rgpc_pkg::CfgDataW-1:0] cfg_rand(input int unsigned hi);
        return rgpc_pkg::CfgDataW'($urandom_range(0, hi));
    endfunction

    // offer one point in bursts with random gaps, return once accepted
    task automatic send_point(input logic [rgpc_pkg::RadiusW-1:0] r,
                              input logic signed [rgpc_pkg::HeightW-1:0] h,
                              input logic f, input logic [rgpc_pkg::IndexW-1:0] idx);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_radius_mm    <= r;
        i_height_mm    <= h;
        i_first_of_ray <= f;
        i_point_index  <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(r, h, f, idx);
    endtask

    // stop offering and wait until every predicted class has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // write all registers in list order plus one index past the list
    task automatic program_regs(input logic [rgpc_pkg::CfgDataW-1:0] lt,
                                input logic [rgpc_pkg::CfgDataW-1:0] it,
                                input logic [rgpc_pkg::CfgDataW-1:0] gt,
                                input logic [rgpc_pkg::CfgDataW-1:0] mh,
                                input logic [rgpc_pkg::CfgDataW-1:0] cg,
                                input logic [rgpc_pkg::CfgDataW-1:0] rg);
        rgpc_pkg::t_cfg_idx            idx_list [7];
        logic [rgpc_pkg::CfgDataW-1:0] val_list [7];
        int                            k;

        idx_list = '{rgpc_pkg::RegLocalSlopeTan, rgpc_pkg::RegInitialSlopeTan,
                     rgpc_pkg::RegGeneralSlopeTan, rgpc_pkg::RegMinHeightMm,
                     rgpc_pkg::RegConcentricGapMm, rgpc_pkg::RegReclassGapMm,
                     ($urandom_range(0, 1) != 0) ? RegSpareHi : RegSpareLo};
        val_list = '{lt, it, gt, mh, cg, rg, rgpc_pkg::CfgDataW'($urandom)};
        for (k = 0; k < 7; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            @(posedge i_clk);
            sb.write_config(idx_list[k], val_list[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // short hand-picked points under the reset register values
    task automatic run_directed();
        send_point(18'd0,      16'sd0,      1'b1, 20'd0);
        send_point(18'd100,    16'sd10,     1'b0, 20'd1);
        // equal radius, then a falling radius
        send_point(18'd100,    16'sd10,     1'b0, 20'd2);
        send_point(18'd50,     16'sd0,      1'b0, 20'd3);
        // height jump with a long step, then a long step back into the band
        send_point(18'd5000,   16'sd2000,   1'b0, 20'd4);
        send_point(18'd5200,   16'sd10,     1'b0, 20'd5);
        send_point(RadiusMax,  16'sd32767,  1'b0, 20'hFFFFF);
        send_point(RadiusMax,  16'sh8000,   1'b0, 20'hAAAAA);
        send_point(RadiusMax,  16'sh8000,   1'b1, 20'h55555);
        send_point(18'd0,      16'sd32767,  1'b1, 20'd9);
        send_point(18'd1,      -16'sd1,     1'b0, 20'd10);
        send_point(18'd300,    -16'sd20,    1'b1, 20'd11);
        send_point(18'd301,    -16'sd70,    1'b0, 20'd12);
        send_point(18'd301,    16'sd31,     1'b0, 20'd13);
        // widest step from the sensor inside one ray
        send_point(18'd0,      16'sd0,      1'b1, 20'd14);
        send_point(RadiusMax,  16'sd1000,   1'b0, 20'd15);
        send_point(18'd2,      16'sd5,      1'b0, 20'd16);
        send_point(18'd131072, -16'sd300,   1'b1, 20'd17);
        send_point(18'd131200, -16'sd290,   1'b0, 20'd18);
    endtask

    // random rays: mostly sorted with small height changes, some noise
    task automatic run_rays(input int n_items);
        int     sent;
        int     ray_left;
        int     kind;
        longint rr;
        longint hh;
        logic   first;

        sent     = 0;
        ray_left = 0;
        rr       = 0;
        hh       = 0;
        while (sent < n_items) begin
            if (ray_left == 0) begin
                ray_left = $urandom_range(1, 24);
                first    = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rr = longint'($urandom_range(0, 262143));
                else
                    rr = longint'($urandom_range(0, 4000));
                hh = longint'($urandom_range(0, 400)) - 200;
            end else begin
                first = ($urandom_range(0, 39) == 0);
                kind  = $urandom_range(0, 19);
                if (kind < 13)
                    rr = rr + longint'($urandom_range(0, 300));
                else if (kind < 16)
                    rr = rr + longint'($urandom_range(0, 5000));
                else if (kind < 18)
                    rr = rr - longint'($urandom_range(0, 500));
                else
                    rr = longint'($urandom_range(0, 262143));
                if ($urandom_range(0, 9) < 8)
                    hh = hh + longint'($urandom_range(0, 160)) - 80;
                else
                    hh = longint'($urandom_range(0, 65535)) - 32768;
            end
            if (rr < 0)
                rr = 0;
            if (rr > 262143)
                rr = 262143;
            if (hh < -32768)
                hh = -32768;
            if (hh > 32767)
                hh = 32767;
            send_point(rr[rgpc_pkg::RadiusW-1:0], hh[rgpc_pkg::HeightW-1:0], first,
                       rgpc_pkg::IndexW'($urandom_range(0, 20'hFFFFF)));
            ray_left--;
            sent++;
        end
    endtask

    // main sequence: reset, directed points, register phases of random rays
    initial begin
        int phase;

        sb = new();
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (phase = 0; phase < NumPhases; phase++) begin
            wait_drained();
            case (phase)
                0: ;
                1: program_regs('0, '0, '0, '0, '0, '0);
                2: program_regs('1, '1, '1, '1, '1, '1);
                3: program_regs(cfg_rand(20000), cfg_rand(20000), cfg_rand(12000),
                                cfg_rand(200), cfg_rand(40), cfg_rand(400));
                4: program_regs(cfg_rand(20000), cfg_rand(20000), cfg_rand(12000),
                                cfg_rand(200), cfg_rand(1500), cfg_rand(400));
                5: program_regs(cfg_rand(32'hFFFFFFFF), cfg_rand(32'hFFFFFFFF),
                                cfg_rand(32'hFFFFFFFF), cfg_rand(32'hFFFFFFFF),
                                cfg_rand(32'hFFFFFFFF), cfg_rand(32'hFFFFFFFF));
                6: program_regs(cfg_rand(20000), cfg_rand(20000), cfg_rand(12000),
                                cfg_rand(200), cfg_rand(40), cfg_rand(400));
                default: program_regs(cfg_rand(262143), cfg_rand(20000),
                                      cfg_rand(262143), cfg_rand(32767),
                                      cfg_rand(40), '0);
            endcase
            // long output hold while points keep coming
            if (phase == 3)
                hold_request = 1'b1;
            run_rays(ItemsPerPhase);
        end
        wait_drained();
        repeat (TailCycles) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
